>>> hw/rtl/nearest_xterm256_color_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest xterm-256 color block
// Implication and next-cycle implication checks, compiled out under
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef NEAREST_XTERM256_COLOR_MACROS_SVH
`define NEAREST_XTERM256_COLOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held
`define NX256_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("nx256 assertion failed");

// Next-cycle implication, disabled while reset is held
`define NX256_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("nx256 assertion failed");

`else

`define NX256_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NX256_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/nx256_pkg.sv
// ----------------------------------------------------------------------------
// nx256_pkg
// Palette constants, types and helpers for the nearest xterm-256 color block.
// ----------------------------------------------------------------------------
package nx256_pkg;

  // One palette color, red in the top byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pal_rgb_t;

  // Squared distance fits 3 * 255 * 255 = 195075
  localparam int unsigned DIST_W = 18;
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  // Palette region boundaries
  localparam logic [7:0] ANSI_COUNT = 8'd16;
  localparam logic [7:0] CUBE_END   = 8'd232;
  localparam logic [7:0] LAST_INDEX = 8'd255;

  // Gray ramp: 8 + 10 * k
  localparam logic [7:0] GRAY_BASE = 8'd8;
  localparam logic [7:0] GRAY_STEP = 8'd10;

  // Cube coordinate runs 0..5
  localparam logic [2:0] CUBE_LAST = 3'd5;

  localparam logic [7:0] CUBE_LEVEL [6] = '{
    8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
  };

  // The sixteen ANSI colors
  localparam pal_rgb_t ANSI_RGB [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  // Absolute difference of two channels
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    if (a > b) begin
      d = a - b;
    end else begin
      d = b - a;
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/nx256_if.sv
// ----------------------------------------------------------------------------
// nx256 channel interfaces
// Valid/ready channels for the color transaction in and the match result out.
// ----------------------------------------------------------------------------

// Color to quantize
interface nx256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// Nearest palette entry
interface nx256_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output palette_index, output red_out,
                  output green_out, output blue_out, output alpha_out,
                  input ready);
  modport sink   (input valid, input palette_index, input red_out,
                  input green_out, input blue_out, input alpha_out,
                  output ready);
endinterface

>>> hw/rtl/nearest_xterm256_color.sv
// ----------------------------------------------------------------------------
// nearest_xterm256_color
// Maps an RGBA color to the nearest entry of the 256-color xterm palette.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one color transaction (red, green, blue, alpha). out_ch
//   returns the palette index of the nearest entry by squared RGB distance,
//   that entry's RGB and the unchanged alpha. Ties resolve to the lowest
//   index.
//   One distance unit (three 8x8 squares, then a sum and compare) visits one
//   palette entry per cycle, index 0 through 255. An accepted color walks
//   the sweep, the square register and the compare stage, then the drain
//   state loads the result; a new color is taken the cycle after that load.
//   The palette sweep sets the pace of the block.
//   in_ch.ready is high only while the sequencer is idle. The result sits in
//   an output register; a new color may be accepted while it waits.
//   If the receiver stalls when the next result is ready, the sequencer
//   holds it and stays busy until the output register frees up.
//   Reset (rst_n low, synchronous) drops any transaction in progress and
//   clears out_ch.valid.
// ----------------------------------------------------------------------------
`include "nearest_xterm256_color_macros.svh"

module nearest_xterm256_color
  import nx256_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nx256_in_if.sink          in_ch,
  nx256_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t              state_r;
  logic [7:0]          red_r, green_r, blue_r, alpha_r;

  // Palette walk
  logic                issuing_r;
  logic [7:0]          idx_r;
  logic [2:0]          cube_r_r, cube_g_r, cube_b_r;
  logic [7:0]          shade_r;
  pal_rgb_t            entry_rgb;

  // Square stage
  logic                s1_valid_r;
  logic                s1_last_r;
  logic [7:0]          s1_idx_r;
  pal_rgb_t            s1_rgb_r;
  logic [15:0]         sq_red_r, sq_green_r, sq_blue_r;
  logic [7:0]          d_red, d_green, d_blue;

  // Compare stage
  logic [DIST_W-1:0]   dist_sum;
  logic                take_new;
  logic [DIST_W-1:0]   win_dist_r;
  logic [7:0]          win_idx_r;
  pal_rgb_t            win_rgb_r;

  // Output register
  logic                out_valid_r;
  logic [7:0]          out_idx_r;
  pal_rgb_t            out_rgb_r;
  logic [7:0]          out_alpha_r;

  logic                in_accept;
  logic                out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.palette_index = out_idx_r;
  assign out_ch.red_out       = out_rgb_r.red;
  assign out_ch.green_out     = out_rgb_r.green;
  assign out_ch.blue_out      = out_rgb_r.blue;
  assign out_ch.alpha_out     = out_alpha_r;

  // Generate the palette color for the current index
  always_comb begin
    priority if (idx_r < ANSI_COUNT) begin
      entry_rgb = ANSI_RGB[idx_r[3:0]];
    end else if (idx_r < CUBE_END) begin
      entry_rgb = '{red: CUBE_LEVEL[cube_r_r], green: CUBE_LEVEL[cube_g_r],
                    blue: CUBE_LEVEL[cube_b_r]};
    end else begin
      entry_rgb = '{red: shade_r, green: shade_r, blue: shade_r};
    end
  end

  // Channel differences feeding the squares
  assign d_red   = abs_diff(red_r,   entry_rgb.red);
  assign d_green = abs_diff(green_r, entry_rgb.green);
  assign d_blue  = abs_diff(blue_r,  entry_rgb.blue);

  // Register squares and the entry they belong to
  always_ff @(posedge clk) begin
    s1_idx_r   <= idx_r;
    s1_last_r  <= (idx_r == LAST_INDEX);
    s1_rgb_r   <= entry_rgb;
    sq_red_r   <= d_red * d_red;
    sq_green_r <= d_green * d_green;
    sq_blue_r  <= d_blue * d_blue;
  end

  // Sum and compare; strict less-than keeps the lowest index on ties
  assign dist_sum = {2'b00, sq_red_r} + {2'b00, sq_green_r} + {2'b00, sq_blue_r};
  assign take_new = s1_valid_r && ((s1_idx_r == '0) || (dist_sum < win_dist_r));

  always_ff @(posedge clk) begin
    if (take_new) begin
      win_dist_r <= dist_sum;
      win_idx_r  <= s1_idx_r;
      win_rgb_r  <= s1_rgb_r;
    end
  end

  // Sequencer, palette walk and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issuing_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issuing_r;

      // Drop the result once the receiver takes it, unless a new one loads
      if (out_valid_r && out_ch.ready && (state_r != ST_DRAIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            red_r     <= in_ch.red_in;
            green_r   <= in_ch.green_in;
            blue_r    <= in_ch.blue_in;
            alpha_r   <= in_ch.alpha_in;
            idx_r     <= '0;
            cube_r_r  <= '0;
            cube_g_r  <= '0;
            cube_b_r  <= '0;
            shade_r   <= GRAY_BASE;
            issuing_r <= 1'b1;
            state_r   <= ST_SWEEP;
          end
        end

        ST_SWEEP: begin
          // Advance the walk one entry per cycle
          if (issuing_r) begin
            idx_r <= idx_r + 8'd1;
            if (idx_r == LAST_INDEX) begin
              issuing_r <= 1'b0;
            end
            if (idx_r >= ANSI_COUNT && idx_r < CUBE_END) begin
              if (cube_b_r == CUBE_LAST) begin
                cube_b_r <= '0;
                if (cube_g_r == CUBE_LAST) begin
                  cube_g_r <= '0;
                  cube_r_r <= cube_r_r + 3'd1;
                end else begin
                  cube_g_r <= cube_g_r + 3'd1;
                end
              end else begin
                cube_b_r <= cube_b_r + 3'd1;
              end
            end
            if (idx_r >= CUBE_END) begin
              shade_r <= shade_r + GRAY_STEP;
            end
          end
          if (s1_valid_r && s1_last_r) begin
            state_r <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          // Hold the winner until the output register frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= win_idx_r;
            out_rgb_r   <= win_rgb_r;
            out_alpha_r <= alpha_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `NX256_ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, in_accept,
    (state_r == ST_SWEEP) && (idx_r == 8'd0) && issuing_r)
  `NX256_ASSERT_IMP(a_stage_only_in_sweep, clk, rst_n, s1_valid_r,
    state_r == ST_SWEEP)
  `NX256_ASSERT_IMP(a_dist_bounded, clk, rst_n, s1_valid_r,
    dist_sum <= MAX_DIST)
  `NX256_ASSERT_IMP(a_gray_entry_neutral, clk, rst_n,
    out_valid_r && (out_idx_r >= CUBE_END),
    (out_rgb_r.red == out_rgb_r.green) && (out_rgb_r.green == out_rgb_r.blue))
  `NX256_ASSERT_NEXT(a_result_from_drain, clk, rst_n,
    (state_r == ST_DRAIN) && out_free,
    out_valid_r && (state_r == ST_IDLE))

endmodule

>>> bench/nx256_match_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nx256_match_monitor
// Watches both channels of the nearest xterm-256 color block. For every
// accepted color it searches its own copy of the palette for the nearest
// entry, queues that answer, and compares each accepted result field by
// field with the oldest queued answer.
// ----------------------------------------------------------------------------
module nx256_match_monitor (
  input  logic  clk,
  input  logic  rst_n,
  nx256_in_if   in_mon,
  nx256_out_if  out_mon,
  output int    fail_count,
  output int    pending_count,
  output int    checked_count,
  output int    ansi_hits,
  output int    cube_hits,
  output int    gray_hits
);

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } xterm_match_t;

  // Palette held here independently of the design's package
  localparam logic [23:0] ANSI_COLORS [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };
  localparam logic [7:0] CUBE_STEPS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
  localparam int FIRST_CUBE = 16;
  localparam int FIRST_GRAY = 232;

  xterm_match_t nearest_queue [$];
  int mismatches = 0;
  int pending    = 0;
  int checked    = 0;
  int ansi_n     = 0;
  int cube_n     = 0;
  int gray_n     = 0;

  assign fail_count    = mismatches;
  assign pending_count = pending;
  assign checked_count = checked;
  assign ansi_hits     = ansi_n;
  assign cube_hits     = cube_n;
  assign gray_hits     = gray_n;

  // RGB of one palette entry
  function automatic logic [23:0] palette_color(input int idx);
    int n;
    logic [7:0] shade;
    logic [23:0] c;
    if (idx < FIRST_CUBE) begin
      c = ANSI_COLORS[idx];
    end else if (idx < FIRST_GRAY) begin
      n = idx - FIRST_CUBE;
      c = {CUBE_STEPS[n / 36], CUBE_STEPS[(n / 6) % 6], CUBE_STEPS[n % 6]};
    end else begin
      shade = 8'(8 + (idx - FIRST_GRAY) * 10);
      c = {shade, shade, shade};
    end
    return c;
  endfunction

  // Full sweep; only a strictly smaller distance replaces the best, so ties
  // keep the lowest index
  function automatic xterm_match_t nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] a);
    int near_idx;
    int near_sq;
    int sq_sum;
    int dr;
    int dg;
    int db;
    logic [23:0] c;
    xterm_match_t m;
    near_idx = 0;
    near_sq  = 32'h7FFF_FFFF;
    for (int i = 0; i < 256; i++) begin
      c  = palette_color(i);
      dr = int'(r) - int'(c[23:16]);
      dg = int'(g) - int'(c[15:8]);
      db = int'(b) - int'(c[7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < near_sq) begin
        near_sq  = sq_sum;
        near_idx = i;
      end
    end
    c = palette_color(near_idx);
    m.index = 8'(near_idx);
    m.red   = c[23:16];
    m.green = c[15:8];
    m.blue  = c[7:0];
    m.alpha = a;
    return m;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want);
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    xterm_match_t want;
    if (!rst_n) begin
      nearest_queue.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        nearest_queue.push_back(nearest_entry(in_mon.red_in, in_mon.green_in,
                                              in_mon.blue_in, in_mon.alpha_in));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (nearest_queue.size() == 0) begin
          report_mismatch("result with no color pending, palette_index",
                          out_mon.palette_index, 8'd0);
        end else begin
          want = nearest_queue.pop_front();
          checked++;
          if (out_mon.palette_index !== want.index)
            report_mismatch("palette_index", out_mon.palette_index, want.index);
          if (out_mon.red_out !== want.red)
            report_mismatch("red_out", out_mon.red_out, want.red);
          if (out_mon.green_out !== want.green)
            report_mismatch("green_out", out_mon.green_out, want.green);
          if (out_mon.blue_out !== want.blue)
            report_mismatch("blue_out", out_mon.blue_out, want.blue);
          if (out_mon.alpha_out !== want.alpha)
            report_mismatch("alpha_out", out_mon.alpha_out, want.alpha);
          if (want.index < FIRST_CUBE) begin
            ansi_n++;
          end else if (want.index < FIRST_GRAY) begin
            cube_n++;
          end else begin
            gray_n++;
          end
        end
      end
    end
    pending = nearest_queue.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives colors into the nearest xterm-256 color block: a directed set of
// exact palette hits, tie points and bit patterns, then random colors that
// are uniform, clustered near palette levels, placed midway between gray
// shades, or on a gray shade with green nudged up. Both channels idle in
// random bursts, and the output side once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS = 1800;
  localparam int LONG_HOLD    = 1500;
  localparam int HOLD_AFTER   = 25;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 300;

  // Directed colors as {red, green, blue, alpha}
  localparam logic [31:0] DIRECTED [20] = '{
    32'h000000_00,  // black, alpha low
    32'hFFFFFF_FF,  // white, alpha high; ties with cube white
    32'h040404_55,  // equal distance to black and first gray
    32'h0D0D0D_AA,  // equal distance to first two grays
    32'hFF0000_01,  // ansi red shadows cube red
    32'h00FF00_80,
    32'h0000EE_7F,
    32'h5C5CFF_FE,
    32'h7F7F7F_F0,
    32'hE5E5E5_0F,
    32'hCD00CD_33,
    32'h808080_CC,  // exact gray shade
    32'h5F87AF_11,  // exact cube entry
    32'hEEEEEE_22,  // last gray
    32'hAA55AA_55,
    32'h55AA55_AA,
    32'h010203_FF,
    32'hFEFDFC_00,
    32'h2F2F2F_5A,
    32'h30C8F0_A5
  };

  // Channel values close to palette levels and their midpoints
  localparam int HOT_VALUES [17] = '{
    0, 47, 48, 92, 95, 115, 127, 135, 155, 175, 195, 205, 215, 229, 235, 238, 255
  };

  logic clk;
  logic rst_n;
  bit   idle_on;

  int mismatch_total;
  int pending_total;
  int checked_total;
  int ansi_total;
  int cube_total;
  int gray_total;

  nx256_in_if  in_ch ();
  nx256_out_if out_ch ();

  nearest_xterm256_color uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nx256_match_monitor match_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (mismatch_total),
    .pending_count (pending_total),
    .checked_count (checked_total),
    .ansi_hits     (ansi_total),
    .cube_hits     (cube_total),
    .gray_hits     (gray_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Offer one color and hold it until the block takes it
  task automatic send_color(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    in_ch.alpha_in <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid for a random burst before the next transaction
  task automatic sender_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // One channel value near a palette level, clamped to the byte range
  function automatic logic [7:0] near_level();
    int v;
    v = HOT_VALUES[$urandom_range(0, 16)] + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_random();
    int kind;
    logic [7:0] s;
    logic [7:0] a;
    kind = $urandom_range(0, 9);
    a = 8'($urandom);
    if (kind < 5) begin
      send_color(8'($urandom), 8'($urandom), 8'($urandom), a);
    end else if (kind < 8) begin
      send_color(near_level(), near_level(), near_level(), a);
    end else if (kind == 8) begin
      // midway between two neighboring grays, which tie with each other
      s = 8'(13 + 10 * $urandom_range(0, 22));
      send_color(s, s, s, a);
    end else begin
      s = 8'(8 + 10 * $urandom_range(0, 23));
      send_color(s, 8'(s + $urandom_range(0, 4)), s, a);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off after a few results
  initial begin
    int taken;
    int hold_left;
    bit long_done;
    taken     = 0;
    hold_left = 0;
    long_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_done && taken == HOLD_AFTER) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int waited;
    idle_on = 1'b1;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.red_in   <= 8'd0;
    in_ch.green_in <= 8'd0;
    in_ch.blue_in  <= 8'd0;
    in_ch.alpha_in <= 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      sender_idle();
      send_color(DIRECTED[i][31:24], DIRECTED[i][23:16], DIRECTED[i][15:8],
                 DIRECTED[i][7:0]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // quiet stretch in the middle and over the final part
      idle_on = !((n >= 600 && n < 800) || n >= RANDOM_ITEMS - 200);
      sender_idle();
      send_random();
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    waited = 0;
    while (pending_total != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d colors quantized and checked, %0d ansi / %0d cube / %0d gray",
             checked_total, ansi_total, cube_total, gray_total);
    $display("summary: long output stall applied, %0d results never returned",
             pending_total);
    if (mismatch_total == 0 && pending_total == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/nx256_pkg.sv
hw/rtl/nx256_if.sv
hw/rtl/nearest_xterm256_color.sv
bench/nx256_match_monitor.sv
bench/testbench.sv
